// ===== rtl/core/pdio_pkg.sv =====
// Shared constants, codes and types for the per-device I/O stats table.
package pdio_pkg;

  localparam int unsigned Slots   = 32;
  localparam int unsigned SlotW   = $clog2(Slots);
  localparam int unsigned CountW  = $clog2(Slots + 1);
  localparam int unsigned Bounds  = 5;
  localparam int unsigned BktW    = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [1:0] ActRead  = 2'd0;
  localparam logic [1:0] ActWrite = 2'd1;
  localparam logic [1:0] ActQuery = 2'd2;

  localparam logic [31:0] BoundReset [Bounds] = '{
    32'd512, 32'd4096, 32'd65536, 32'd1048576, 32'd10485760
  };

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture input beat, start tag search
    logic update;  // read-modify-write of the loaded beat
  } pdio_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_valid;
  } pdio_sts_t;

endpackage

// ===== rtl/core/pdio_ctrl.sv =====
// Controller: idle/update sequencer for accepted beats and output handshake.
module pdio_ctrl import pdio_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pdio_sts_t sts_i,
  input  logic      out_stall_i,
  output pdio_cmd_t cmd_o
);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StUpd  = 1'b1;

  logic [0:0] state_q, state_d;

  // a new beat waits until the previous result has left the output register
  // or leaves in this cycle
  logic can_take;
  assign can_take   = (state_q == StIdle) && (!sts_i.out_valid || !out_stall_i);
  assign in_stall_o = !can_take;
  assign cmd_o.load   = can_take && in_valid_i;
  assign cmd_o.update = (state_q == StUpd);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (cmd_o.load) state_d = StUpd;
      StUpd:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.update) else $error("update did not follow load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> !cmd_o.update) else $error("update lasted two cycles");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.update)) else $error("load during update");

endmodule

// ===== rtl/core/pdio_datapath.sv =====
// Datapath: tag table, per-slot counter memory, histogram, totals, result.
module pdio_datapath import pdio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pdio_cmd_t   cmd_i,
  output pdio_sts_t   sts_o,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] device_id_i,
  input  logic [31:0] byte_count_i,
  input  logic [31:0] latency_i,
  input  logic [2:0]  bucket_index_i,
  input  logic        out_stall_i,
  output logic        table_full_o,
  output logic [4:0]  slot_o,
  output logic [2:0]  size_bucket_o,
  output logic [63:0] bucket_count_o,
  output logic [63:0] device_bytes_o,
  output logic [63:0] device_ops_o,
  output logic [63:0] device_time_o,
  output logic [63:0] all_read_ops_o,
  output logic [63:0] all_write_ops_o,
  output logic [63:0] all_read_bytes_o,
  output logic [63:0] all_write_bytes_o,
  output logic [5:0]  active_devices_o
);

  logic [31:0] bound_q [Bounds];
  logic [Slots-1:0] valid_q;
  logic [31:0] tag_q [Slots];
  logic [63:0] rbytes_mem [Slots];
  logic [63:0] wbytes_mem [Slots];
  logic [63:0] rops_mem   [Slots];
  logic [63:0] wops_mem   [Slots];
  logic [63:0] lat_mem    [Slots];
  logic [63:0] hist_q [Bounds+1];
  logic [63:0] rev_q, wev_q, rbt_q, wbt_q;
  logic [CountW-1:0] claimed_q;

  // captured beat
  logic [1:0]  act_q;
  logic [31:0] bytes_q, lat_q;
  logic [2:0]  bidx_q;
  logic [SlotW-1:0] slot_q;
  logic        hit_q, free_q;
  logic [BktW-1:0] bkt_q;
  logic [63:0] rd_bytes_q, rd_ops_q, rd_lat_q;

  // tag search
  logic [Slots-1:0] match;
  logic [SlotW-1:0] hit_idx, free_idx;
  logic hit_any, free_any;
  logic [BktW-1:0] bkt_c;
  always_comb begin
    for (int i = 0; i < Slots; i++)
      match[i] = valid_q[i] && (tag_q[i] == device_id_i);
    hit_any = |match;  free_any = !(&valid_q);
    hit_idx = '0;  free_idx = '0;
    for (int i = Slots-1; i >= 0; i--) begin
      if (match[i])    hit_idx  = SlotW'(i);
      if (!valid_q[i]) free_idx = SlotW'(i);
    end
    bkt_c = BktW'(Bounds);
    for (int i = Bounds-1; i >= 0; i--)
      if (byte_count_i <= bound_q[i]) bkt_c = BktW'(i);
  end

  logic [SlotW-1:0] sel_idx;
  assign sel_idx = hit_any ? hit_idx : free_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;  bytes_q <= byte_count_i;  lat_q <= latency_i;
      bidx_q <= bucket_index_i;  slot_q <= sel_idx;
      hit_q <= hit_any;  free_q <= free_any;  bkt_q <= bkt_c;
      rd_bytes_q <= (action_i == ActRead) ? rbytes_mem[sel_idx] : wbytes_mem[sel_idx];
      rd_ops_q   <= (action_i == ActRead) ? rops_mem[sel_idx]   : wops_mem[sel_idx];
      rd_lat_q   <= lat_mem[sel_idx];
    end
  end

  logic is_ev, do_upd, is_rd;
  logic [63:0] nb, no, nl, nh, bc_q_c;
  assign is_ev  = (act_q == ActRead) || (act_q == ActWrite);
  assign is_rd  = (act_q == ActRead);
  assign do_upd = cmd_i.update && is_ev && (hit_q || free_q);
  assign nb = (hit_q ? rd_bytes_q : 64'd0) + {32'd0, bytes_q};
  assign no = (hit_q ? rd_ops_q   : 64'd0) + 64'd1;
  assign nl = (hit_q ? rd_lat_q   : 64'd0) + {32'd0, lat_q};
  assign nh = hist_q[bkt_q] + 64'd1;
  assign bc_q_c = (bidx_q <= BktW'(Bounds)) ? hist_q[bidx_q] : 64'd0;

  // per-slot memories; claim writes the cleared-then-updated values
  always_ff @(posedge clk_i) begin
    if (do_upd) begin
      lat_mem[slot_q] <= nl;
      if (is_rd) begin
        rbytes_mem[slot_q] <= nb;  rops_mem[slot_q] <= no;
        if (!hit_q) begin wbytes_mem[slot_q] <= '0; wops_mem[slot_q] <= '0; end
      end else begin
        wbytes_mem[slot_q] <= nb;  wops_mem[slot_q] <= no;
        if (!hit_q) begin rbytes_mem[slot_q] <= '0; rops_mem[slot_q] <= '0; end
      end
    end
  end

  logic [31:0] id_q;
  always_ff @(posedge clk_i) if (cmd_i.load) id_q <= device_id_i;
  always_ff @(posedge clk_i) if (do_upd && !hit_q) tag_q[slot_q] <= id_q;

  logic out_v_q;
  assign sts_o.out_valid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Bounds; i++) bound_q[i] <= BoundReset[i];
      for (int i = 0; i <= Bounds; i++) hist_q[i] <= '0;
      valid_q <= '0;  claimed_q <= '0;
      rev_q <= '0;  wev_q <= '0;  rbt_q <= '0;  wbt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < CfgIdxW'(Bounds)))
        bound_q[cfg_idx_i] <= cfg_data_i;
      if (do_upd) begin
        hist_q[bkt_q] <= nh;
        if (!hit_q) begin valid_q[slot_q] <= 1'b1; claimed_q <= claimed_q + 1'b1; end
        if (is_rd) begin rev_q <= rev_q + 64'd1; rbt_q <= rbt_q + {32'd0, bytes_q}; end
        else       begin wev_q <= wev_q + 64'd1; wbt_q <= wbt_q + {32'd0, bytes_q}; end
      end
      if (cmd_i.update)              out_v_q <= 1'b1;
      else if (!out_stall_i)         out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      table_full_o   <= is_ev && !hit_q && !free_q;
      slot_o         <= do_upd ? 5'(slot_q) : 5'd0;
      size_bucket_o  <= do_upd ? bkt_q : 3'd0;
      bucket_count_o <= do_upd ? nh : ((act_q == ActQuery) ? bc_q_c : 64'd0);
      device_bytes_o <= do_upd ? nb : 64'd0;
      device_ops_o   <= do_upd ? no : 64'd0;
      device_time_o  <= do_upd ? nl : 64'd0;
    end
  end

  assign all_read_ops_o    = rev_q;
  assign all_write_ops_o   = wev_q;
  assign all_read_bytes_o  = rbt_q;
  assign all_write_bytes_o = wbt_q;
  assign active_devices_o  = 6'(claimed_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(claimed_q)) else $error("claim count drift");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_upd |-> (hit_q || !valid_q[slot_q])) else $error("claimed a used slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i && !cmd_i.update) |=> $stable(bucket_count_o))
    else $error("held result changed");

endmodule

// ===== rtl/core/per_device_io_stats_table_unit.sv =====
// Per-device disk I/O statistics table with size histogram (top level).
// An accepted beat has its tag search and per-slot counter read in the load
// step, then its read-modify-write and result register in the update step;
// a new beat is taken only after the update, once the result can leave.
// Reset: slot valid bits, histogram and totals clear, bounds return to their
// defaults at once; no clearing pass, counters are overwritten on a claim.
// Totals are shown live from their registers and match the latest result.
module per_device_io_stats_table_unit import pdio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] device_id_i,
  input  logic [31:0] byte_count_i,
  input  logic [31:0] latency_i,
  input  logic [2:0]  bucket_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        table_full_o,
  output logic [4:0]  slot_o,
  output logic [2:0]  size_bucket_o,
  output logic [63:0] bucket_count_o,
  output logic [63:0] device_bytes_o,
  output logic [63:0] device_ops_o,
  output logic [63:0] device_time_o,
  output logic [63:0] all_read_ops_o,
  output logic [63:0] all_write_ops_o,
  output logic [63:0] all_read_bytes_o,
  output logic [63:0] all_write_bytes_o,
  output logic [5:0]  active_devices_o
);

  pdio_cmd_t cmd;
  pdio_sts_t sts;

  // bounds registers are always writable
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = sts.out_valid;

  pdio_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i(sts), .out_stall_i, .cmd_o(cmd)
  );

  pdio_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .action_i, .device_id_i, .byte_count_i, .latency_i, .bucket_index_i,
    .out_stall_i, .table_full_o, .slot_o, .size_bucket_o, .bucket_count_o,
    .device_bytes_o, .device_ops_o, .device_time_o, .all_read_ops_o,
    .all_write_ops_o, .all_read_bytes_o, .all_write_bytes_o, .active_devices_o
  );

endmodule

// ===== tb/tb_per_device_io_stats_table_unit.sv =====
// Self-checking testbench for the per-device I/O stats table unit.
module tb_per_device_io_stats_table_unit;
  import pdio_pkg::*;

  // One input beat: an I/O event or a histogram query.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] dev_id;
    logic [31:0] nbytes;
    logic [31:0] lat;
    logic [2:0]  bidx;
  } io_beat_t;

  // One result beat, field for field as on the output ports.
  typedef struct packed {
    logic        full;
    logic [4:0]  slot;
    logic [2:0]  bucket;
    logic [63:0] bcount;
    logic [63:0] dbytes;
    logic [63:0] dops;
    logic [63:0] dtime;
    logic [63:0] rd_ops;
    logic [63:0] wr_ops;
    logic [63:0] rd_bytes;
    logic [63:0] wr_bytes;
    logic [5:0]  active;
  } stats_beat_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdPool     = 40;
  localparam logic [1:0]  ActIgnored = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ActRead;
  logic [31:0] device_id_i = '0;
  logic [31:0] byte_count_i = '0;
  logic [31:0] latency_i = '0;
  logic [2:0]  bucket_index_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        table_full_o;
  logic [4:0]  slot_o;
  logic [2:0]  size_bucket_o;
  logic [63:0] bucket_count_o;
  logic [63:0] device_bytes_o;
  logic [63:0] device_ops_o;
  logic [63:0] device_time_o;
  logic [63:0] all_read_ops_o;
  logic [63:0] all_write_ops_o;
  logic [63:0] all_read_bytes_o;
  logic [63:0] all_write_bytes_o;
  logic [5:0]  active_devices_o;

  per_device_io_stats_table_unit uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the table, histogram and totals.
  // ---------------------------------------------------------------------
  logic [31:0] bound_q   [Bounds];
  logic        tag_valid [Slots];
  logic [31:0] tag_id    [Slots];
  logic [63:0] rd_sum    [Slots];
  logic [63:0] wr_sum    [Slots];
  logic [63:0] rd_cnt    [Slots];
  logic [63:0] wr_cnt    [Slots];
  logic [63:0] lat_sum   [Slots];
  logic [63:0] size_hist [Bounds+1];
  logic [63:0] tot_rd_ops, tot_wr_ops, tot_rd_bytes, tot_wr_bytes;
  logic [5:0]  n_claimed;

  io_beat_t    pending_beats[$];
  stats_beat_t expected_stats[$];
  logic [31:0] dev_pool[IdPool];

  int unsigned cycle_cnt = 0;
  int unsigned n_errors = 0;
  int unsigned n_events = 0, n_drops = 0, n_queries = 0, n_results = 0;

  // Tag lookup, lowest matching slot else lowest free slot (claimed here).
  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < Slots; i++)
      if (tag_valid[i] && tag_id[i] == id) return i;
    for (int i = 0; i < Slots; i++) begin
      if (!tag_valid[i]) begin
        tag_valid[i] = 1'b1;
        tag_id[i]    = id;
        rd_sum[i]    = '0;
        wr_sum[i]    = '0;
        rd_cnt[i]    = '0;
        wr_cnt[i]    = '0;
        lat_sum[i]   = '0;
        n_claimed++;
        return i;
      end
    end
    return -1;
  endfunction

  // Advance the table by one beat and return the stats it should report.
  function automatic stats_beat_t update_stats(io_beat_t b);
    stats_beat_t r;
    int s;
    int k;
    r = '0;
    if (b.action == ActRead || b.action == ActWrite) begin
      s = find_slot(b.dev_id);
      if (s < 0) begin
        r.full = 1'b1;
        n_drops++;
      end else begin
        k = Bounds;
        for (int i = Bounds - 1; i >= 0; i--)
          if (b.nbytes <= bound_q[i]) k = i;
        if (b.action == ActRead) begin
          rd_sum[s] += b.nbytes;
          rd_cnt[s] += 1;
          tot_rd_ops += 1;
          tot_rd_bytes += b.nbytes;
          r.dbytes = rd_sum[s];
          r.dops   = rd_cnt[s];
        end else begin
          wr_sum[s] += b.nbytes;
          wr_cnt[s] += 1;
          tot_wr_ops += 1;
          tot_wr_bytes += b.nbytes;
          r.dbytes = wr_sum[s];
          r.dops   = wr_cnt[s];
        end
        lat_sum[s] += b.lat;
        size_hist[k] += 1;
        r.dtime  = lat_sum[s];
        r.bcount = size_hist[k];
        r.slot   = s[4:0];
        r.bucket = k[2:0];
        n_events++;
      end
    end else begin
      // query, or the unused action code which reads like an empty bucket
      if (b.action == ActQuery && b.bidx <= Bounds) r.bcount = size_hist[b.bidx];
      n_queries++;
    end
    r.rd_ops   = tot_rd_ops;
    r.wr_ops   = tot_wr_ops;
    r.rd_bytes = tot_rd_bytes;
    r.wr_bytes = tot_wr_bytes;
    r.active   = n_claimed;
    return r;
  endfunction

  // Take a break with probability 11 in 100, except in one long window without breaks.
  function automatic bit take_break();
    if (cycle_cnt >= 3000 && cycle_cnt < 6000) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents pending beats, predicts on each accepted beat.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    io_beat_t nb;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_stats.push_back(update_stats({action_i, device_id_i, byte_count_i,
                                               latency_i, bucket_index_i}));
      // payload holds while stalled; a new beat only after acceptance
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() > 0 && !take_break()) begin
          nb = pending_beats.pop_front();
          in_valid_i     <= 1'b1;
          action_i       <= nb.action;
          device_id_i    <= nb.dev_id;
          byte_count_i   <= nb.nbytes;
          latency_i      <= nb.lat;
          bucket_index_i <= nb.bidx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: compares each accepted result beat with the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    stats_beat_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_stats.size() == 0) begin
          $error("result beat with no prediction pending");
          n_errors++;
        end else begin
          e = expected_stats.pop_front();
          check_field("table_full", e.full, table_full_o);
          check_field("slot", e.slot, slot_o);
          check_field("size_bucket", e.bucket, size_bucket_o);
          check_field("bucket_count", e.bcount, bucket_count_o);
          check_field("device_bytes", e.dbytes, device_bytes_o);
          check_field("device_ops", e.dops, device_ops_o);
          check_field("device_time", e.dtime, device_time_o);
          check_field("all_read_ops", e.rd_ops, all_read_ops_o);
          check_field("all_write_ops", e.wr_ops, all_write_ops_o);
          check_field("all_read_bytes", e.rd_bytes, all_read_bytes_o);
          check_field("all_write_bytes", e.wr_bytes, all_write_bytes_o);
          check_field("active_devices", e.active, active_devices_o);
        end
      end
      out_stall_i <= take_break();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_per_device_io_stats_table_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic io_beat_t mk(logic [1:0] a, logic [31:0] id, logic [31:0] nb,
                                  logic [31:0] lt, logic [2:0] bi);
    io_beat_t b;
    b = '{action: a, dev_id: id, nbytes: nb, lat: lt, bidx: bi};
    return b;
  endfunction

  // Random beat: mostly pooled ids (the pool exceeds the table, so drops
  // happen once it fills), sizes aimed at bucket edges part of the time.
  function automatic io_beat_t rand_beat();
    io_beat_t b;
    int unsigned pick;
    b.action = $urandom_range(0, 99) < 8 ? ActQuery : logic'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 2) b.action = ActIgnored;
    b.dev_id = $urandom_range(0, 99) < 5 ? $urandom() : dev_pool[$urandom_range(0, IdPool-1)];
    pick = $urandom_range(0, 9);
    if (pick < 4) b.nbytes = $urandom();
    else if (pick < 7) b.nbytes = bound_q[$urandom_range(0, Bounds-1)]
                                  + 32'($urandom_range(0, 2)) - 32'd1;
    else b.nbytes = $urandom_range(0, 20000);
    b.lat  = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100000);
    b.bidx = $urandom_range(0, 7);
    return b;
  endfunction

  // Block is idle: nothing queued, nothing driven, nothing owed.
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || expected_stats.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < Bounds) bound_q[idx] = data;
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) pending_beats.push_back(rand_beat());
    drain();
  endtask

  initial begin
    logic [31:0] v;
    for (int i = 0; i < Bounds; i++) bound_q[i] = BoundReset[i];
    for (int i = 0; i < Slots; i++) tag_valid[i] = 1'b0;
    for (int i = 0; i <= Bounds; i++) size_hist[i] = '0;
    tot_rd_ops = '0; tot_wr_ops = '0; tot_rd_bytes = '0; tot_wr_bytes = '0;
    n_claimed = '0;
    dev_pool[0] = 32'h0;
    dev_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < IdPool; i++) dev_pool[i] = $urandom();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, repeat hits, every query index, unused action.
    pending_beats.push_back(mk(ActRead,  32'h0, 32'h0, 32'h0, 3'd0));
    pending_beats.push_back(mk(ActWrite, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7));
    pending_beats.push_back(mk(ActWrite, 32'h0, 32'd512, 32'd1, 3'd0));
    pending_beats.push_back(mk(ActRead,  32'hFFFF_FFFF, 32'd513, 32'hFFFF_FFFF, 3'd0));
    pending_beats.push_back(mk(ActRead,  32'h5A5A_A5A5, 32'd10485760, 32'd7, 3'd0));
    pending_beats.push_back(mk(ActRead,  32'h5A5A_A5A5, 32'd10485761, 32'd7, 3'd0));
    for (int i = 0; i < 8; i++)
      pending_beats.push_back(mk(ActQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'(i)));
    pending_beats.push_back(mk(ActIgnored, 32'h0, 32'd100, 32'd100, 3'd1));
    drain();

    // Reset bounds, then all-zero, all-ones, random and ignored indexes.
    run_random(350);
    for (int i = 0; i < Bounds; i++) write_reg(3'(i), 32'h0);
    run_random(300);
    for (int i = 0; i < Bounds; i++) write_reg(3'(i), 32'hFFFF_FFFF);
    run_random(300);
    v = 32'd0;
    for (int i = 0; i < Bounds; i++) begin
      v = v + $urandom_range(1, 1 << 24);
      write_reg(3'(i), v);
    end
    run_random(400);
    for (int i = Bounds; i < 8; i++) write_reg(3'(i), $urandom());
    for (int i = 0; i < Bounds; i++) write_reg(3'(i), $urandom());
    run_random(400);

    drain();
    $display("covered %0d accepted events, %0d dropped on a full table, %0d queries",
             n_events, n_drops, n_queries);
    $display("%0d result beats checked under five bucket-bound settings", n_results);
    if (n_errors == 0) begin
      $display("tb_per_device_io_stats_table_unit passed");
    end else begin
      $display("tb_per_device_io_stats_table_unit failed");
    end
    $finish;
  end

endmodule
